### rtl/dnsle_pkg.sv
// Shared types and constants for the DNS name label encoder.
// No dependencies; every other file of the block imports this package.
package dnsle_pkg;

   // Longest label carried on the wire; longer labels are cut to this.
   localparam int MAX_LABEL = 63;
   // Label character count, able to hold MAX_LABEL itself.
   localparam int LBL_CW    = $clog2(MAX_LABEL + 1);
   // Address into the label store, which holds MAX_LABEL entries.
   localparam int LBL_AW    = $clog2(MAX_LABEL);

   localparam logic [7:0] DOT_CHAR  = 8'd46;
   localparam logic [7:0] ROOT_BYTE = 8'd0;

   localparam logic MODE_CHAR = 1'b0;
   localparam logic MODE_END  = 1'b1;

   typedef struct packed {
      logic       mode;
      logic [7:0] char_byte;
   } req_word_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_word_type;

   // Port controls that the sequencer hands to the label store.
   typedef struct packed {
      logic              wr_en;
      logic [LBL_AW-1:0] wr_addr;
      logic [7:0]        wr_data;
      logic [LBL_AW-1:0] rd_addr;
   } ram_ctl_type;

endpackage

### rtl/dns_name_label_encoder_unit.sv
// Top level of the DNS name label encoder: sequencer plus label store.
// Depends on dnsle_pkg, dnsle_ctrl and dnsle_label_ram.

// Turns a dotted host name, one character word at a time, into DNS wire
// format. Characters are written to a 63-entry label store, producing no
// output, and can be taken back to back. A dot or an end-of-name word (and a
// label that reaches 63 characters) starts a readout: the length byte, then
// one character per cycle from the store while the result side keeps up,
// then the zero root byte at the end of a name; an empty last label gives
// only the root byte. The single read port of the label store sets that
// pace. New words are taken only between readouts. Characters beyond 63
// in a label are dropped up to and including the next dot, and last_of_run
// marks the final word caused by each input word.
module dns_name_label_encoder_unit (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dnsle_pkg::req_word_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dnsle_pkg::rsp_word_type rsp_data
);
   import dnsle_pkg::*;

   ram_ctl_type ram_ctl;
   logic [7:0]  rd_data;

   dnsle_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .ram_ctl   (ram_ctl),
      .rd_data   (rd_data)
   );

   dnsle_label_ram u_ram (
      .clock   (clock),
      .ram_ctl (ram_ctl),
      .rd_data (rd_data)
   );

endmodule

### rtl/dnsle_label_ram.sv
// Label character store: one write port and one read port with registered data.
// Depends on dnsle_pkg for the depth, address width and control struct.
module dnsle_label_ram (
   input  logic                   clock,
   input  dnsle_pkg::ram_ctl_type ram_ctl,
   output logic [7:0]             rd_data
);
   import dnsle_pkg::*;

   logic [7:0] mem_ff [MAX_LABEL];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (ram_ctl.wr_en) begin
         mem_ff[ram_ctl.wr_addr] <= ram_ctl.wr_data;
      end
      rd_data_ff <= mem_ff[ram_ctl.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/dnsle_ctrl.sv
// Sequencer of the label encoder: label bookkeeping, readout of the label store
// and the result output register. Depends on dnsle_pkg.
module dnsle_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  dnsle_pkg::req_word_type req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output dnsle_pkg::rsp_word_type rsp_data,
   output dnsle_pkg::ram_ctl_type  ram_ctl,
   input  logic [7:0]              rd_data
);
   import dnsle_pkg::*;

   typedef enum logic [1:0] {
      S_IDLE,
      S_LEN,
      S_CHR,
      S_ROOT
   } state_type;

   state_type         state_ff, state_in;
   logic [LBL_CW-1:0] count_ff, count_in;
   logic              discard_ff, discard_in;
   logic [LBL_CW-1:0] len_ff, len_in;
   logic              root_ff, root_in;
   logic [LBL_AW-1:0] idx_ff, idx_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic              req_fire;
   logic              out_free;
   logic              last_chr;
   logic [LBL_CW-1:0] count_inc;

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign count_inc = count_ff + LBL_CW'(1);
   assign last_chr  = (LBL_CW'(idx_ff) == (len_ff - LBL_CW'(1)));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      discard_in   = discard_ff;
      len_in       = len_ff;
      root_in      = root_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;

      ram_ctl.wr_en   = 1'b0;
      ram_ctl.wr_addr = count_ff[LBL_AW-1:0];
      ram_ctl.wr_data = req_data.char_byte;

      unique case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            if (req_fire) begin
               if (req_data.mode == MODE_END) begin
                  len_in     = count_ff;
                  root_in    = 1'b1;
                  count_in   = '0;
                  discard_in = 1'b0;
                  state_in   = (count_ff != '0) ? S_LEN : S_ROOT;
               end else if (req_data.char_byte == DOT_CHAR) begin
                  count_in = '0;
                  if (discard_ff) begin
                     discard_in = 1'b0;
                  end else begin
                     len_in   = count_ff;
                     root_in  = 1'b0;
                     state_in = S_LEN;
                  end
               end else if (!discard_ff) begin
                  ram_ctl.wr_en = 1'b1;
                  count_in      = count_inc;
                  // A label that reaches full length goes out right away.
                  if (count_inc == LBL_CW'(MAX_LABEL)) begin
                     len_in     = count_inc;
                     root_in    = 1'b0;
                     count_in   = '0;
                     discard_in = 1'b1;
                     state_in   = S_LEN;
                  end
               end
            end
         end
         S_LEN: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.out_byte    = 8'(len_ff);
               rsp_word_in.last_of_run = (len_ff == '0) && !root_ff;
               if (len_ff != '0) begin
                  state_in = S_CHR;
               end else begin
                  state_in = root_ff ? S_ROOT : S_IDLE;
               end
            end
         end
         S_CHR: begin
            // The store is read at the next index each cycle, so rd_data
            // always holds the character at idx_ff here.
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.out_byte    = rd_data;
               rsp_word_in.last_of_run = last_chr && !root_ff;
               if (last_chr) begin
                  state_in = root_ff ? S_ROOT : S_IDLE;
               end else begin
                  idx_in = idx_ff + LBL_AW'(1);
               end
            end
         end
         S_ROOT: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_word_in.out_byte    = ROOT_BYTE;
               rsp_word_in.last_of_run = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      ram_ctl.rd_addr = idx_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         discard_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         discard_ff   <= discard_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      len_ff      <= len_in;
      root_ff     <= root_in;
      idx_ff      <= idx_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

endmodule

### rtl/dnsle_checker.sv
// Port-level checks for the DNS name label encoder, bound to the top level.
// Depends on dnsle_pkg and dns_name_label_encoder_unit.
module dnsle_checker (
   input logic                    clock,
   input logic                    reset,
   input logic                    req_valid,
   input logic                    req_ready,
   input dnsle_pkg::req_word_type req_data,
   input logic                    rsp_valid,
   input logic                    rsp_ready,
   input dnsle_pkg::rsp_word_type rsp_data
);
   import dnsle_pkg::*;

   // Nothing is offered on the result side right after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result word holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result word changed");

   // An end-of-name word always produces output, so the block is busy next.
   a_end_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_data.mode == MODE_END |=> !req_ready)
      else $error("ready right after end of name");

   // While taking input, only the final word of a run may still be waiting.
   a_idle_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && req_ready |-> rsp_data.last_of_run)
      else $error("input taken in the middle of a run");

endmodule

bind dns_name_label_encoder_unit dnsle_checker u_checker (.*);
